@@ rtl/core/utfw_pkg.sv @@
`default_nettype none

package utfw_pkg;

  // Longest sequence a lead byte can open, and results one request can cause.
  localparam int unsigned SEQ_MAX     = 6;
  localparam int unsigned MAX_RESULTS = 3;

  // Default depth of the result queue; must be at least MAX_RESULTS.
  localparam int unsigned OUT_DEPTH   = 4;

  typedef enum logic {
    MODE_UTF16 = 1'b0,
    MODE_UTF32 = 1'b1
  } unit_mode_e;

  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [31:0] CODE_MAX     = 32'h0010_FFFF;
  localparam logic [31:0] SURR_FIRST   = 32'h0000_D800;
  localparam logic [31:0] SURR_LAST    = 32'h0000_DFFF;
  localparam logic [31:0] REPLACEMENT  = 32'h0000_003F;

  // Offset removed after summing a sequence of length index+1.
  localparam logic [SEQ_MAX-1:0][31:0] SEQ_OFFSETS = '{
    32'h8208_2080, 32'hFA08_2080, 32'h03C8_2080,
    32'h000E_2080, 32'h0000_3080, 32'h0000_0000
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [31:0] code_unit;
    logic        last;
  } out_t;

  // Results caused by one request, in order from item[0].
  typedef struct packed {
    logic [1:0]                   count;
    out_t [MAX_RESULTS-1:0]       item;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/utfw_decode.sv @@
`default_nettype none

module utfw_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          accept_i,
  input  utfw_pkg::in_t in_data_i,
  output utfw_pkg::res_t res_o
);
  import utfw_pkg::*;

  logic [SEQ_MAX-1:0][7:0] held_q, held_d, seq;
  logic [2:0]              cnt_q, cnt_d;
  logic [2:0]              need_q, need_d;
  unit_mode_e              mode_q;

  logic [2:0]  len, len_eff;
  logic        emit, term, clear;
  logic [7:0]  in_byte;
  logic [9:0]  plane;
  logic [31:0] u_a, u_b, sum, val;
  logic [1:0]  nseq;
  out_t        term_item, item_a, item_b;

  function automatic logic [2:0] seq_length(input logic [7:0] b, input unit_mode_e m);
    logic [2:0] n;
    n = 3'd1;
    if (m == MODE_UTF16) begin
      if (b[7:3] == 5'b11110)      n = 3'd4;
      else if (b[7:4] == 4'b1110)  n = 3'd3;
      else if (b[7:5] == 3'b110)   n = 3'd2;
    end else begin
      if (b >= 8'hFC)      n = 3'd6;
      else if (b >= 8'hF8) n = 3'd5;
      else if (b >= 8'hF0) n = 3'd4;
      else if (b >= 8'hE0) n = 3'd3;
      else if (b >= 8'hC0) n = 3'd2;
    end
    return n;
  endfunction

  assign in_byte = in_data_i.data_byte;

  // Collect bytes to the lead byte's length; a lead NUL or end flag terminates.
  always_comb begin
    seq    = held_q;
    len    = need_q;
    held_d = held_q;
    cnt_d  = cnt_q;
    need_d = need_q;
    emit   = 1'b0;
    term   = 1'b0;
    clear  = 1'b0;
    if (in_data_i.end_of_text) begin
      emit  = (cnt_q != 3'd0);
      term  = 1'b1;
      clear = 1'b1;
    end else if (cnt_q == 3'd0) begin
      if (in_byte == 8'h00) begin
        term  = 1'b1;
        clear = 1'b1;
      end else begin
        seq[0] = in_byte;
        len    = seq_length(in_byte, mode_q);
        if (len <= 3'd1) begin
          emit  = 1'b1;
          clear = 1'b1;
        end else begin
          held_d = seq;
          cnt_d  = 3'd1;
          need_d = len;
        end
      end
    end else begin
      if (cnt_q < 3'(SEQ_MAX)) seq[cnt_q] = in_byte;
      if (({1'b0, cnt_q} + 4'd1) >= {1'b0, need_q}) begin
        emit  = 1'b1;
        clear = 1'b1;
      end else begin
        held_d = seq;
        cnt_d  = cnt_q + 3'd1;
      end
    end
    if (clear) begin
      held_d = '0;
      cnt_d  = 3'd0;
      need_d = 3'd0;
    end
  end

  assign len_eff = (len == 3'd0 || len > 3'(SEQ_MAX)) ? 3'd1 : len;

  // 32-bit units: weighted sum less offset, mod 2^32; invalid -> REPLACEMENT.
  always_comb begin
    case (len_eff)
      3'd2: sum = (32'(seq[0]) << 6) + 32'(seq[1]);
      3'd3: sum = (32'(seq[0]) << 12) + (32'(seq[1]) << 6) + 32'(seq[2]);
      3'd4: sum = (32'(seq[0]) << 18) + (32'(seq[1]) << 12) + (32'(seq[2]) << 6)
                + 32'(seq[3]);
      3'd5: sum = (32'(seq[0]) << 24) + (32'(seq[1]) << 18) + (32'(seq[2]) << 12)
                + (32'(seq[3]) << 6) + 32'(seq[4]);
      3'd6: sum = (32'(seq[0]) << 30) + (32'(seq[1]) << 24) + (32'(seq[2]) << 18)
                + (32'(seq[3]) << 12) + (32'(seq[4]) << 6) + 32'(seq[5]);
      default: sum = 32'(seq[0]);
    endcase
    val = sum - SEQ_OFFSETS[3'(len_eff - 3'd1)];
    if (val > CODE_MAX || val inside {[SURR_FIRST:SURR_LAST]}) val = REPLACEMENT;
  end

  // 16-bit units; a four-byte sequence becomes a surrogate pair.
  assign plane = 10'({seq[0][2:0], seq[1][5:4]}) - 10'd1;

  always_comb begin
    u_b  = 32'(LO_SURR_BASE | {6'b0, seq[2][3:0], seq[3][5:0]});
    nseq = 2'd0;
    if (mode_q == MODE_UTF32) begin
      u_a = val;
    end else begin
      case (len_eff)
        3'd4:    u_a = 32'(HI_SURR_BASE | {plane, seq[1][3:0], seq[2][5:4]});
        3'd3:    u_a = 32'({seq[0][3:0], seq[1][5:0], seq[2][5:0]});
        3'd2:    u_a = 32'({seq[0][4:0], seq[1][5:0]});
        default: u_a = 32'(seq[0]);
      endcase
    end
    if (emit) begin
      nseq = (mode_q == MODE_UTF16 && len_eff == 3'd4) ? 2'd2 : 2'd1;
    end
  end

  assign term_item = '{code_unit: 32'd0, last: 1'b1};
  assign item_a    = '{code_unit: u_a, last: 1'b0};
  assign item_b    = '{code_unit: u_b, last: 1'b0};

  always_comb begin
    res_o.count   = nseq + {1'b0, term};
    res_o.item[0] = (nseq != 2'd0) ? item_a : term_item;
    res_o.item[1] = (nseq == 2'd2) ? item_b : term_item;
    res_o.item[2] = term_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cnt_q  <= 3'd0;
      need_q <= 3'd0;
      mode_q <= MODE_UTF16;
    end else begin
      if (accept_i) begin
        held_q <= held_d;
        cnt_q  <= cnt_d;
        need_q <= need_d;
      end
      if (cfg_we_i) mode_q <= unit_mode_e'(cfg_wdata_i);
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/utfw_out_queue.sv @@
`default_nettype none

module utfw_out_queue #(
  parameter int unsigned Depth = utfw_pkg::OUT_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  utfw_pkg::res_t push_data_i,
  output logic           room_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output utfw_pkg::out_t out_data_o
);
  import utfw_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned SumW = $clog2(2 * Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  out_t [Depth-1:0] mem_q;
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [1:0]       n_push;
  logic             pop;

  function automatic logic [PtrW-1:0] ptr_add(input logic [PtrW-1:0] p, input logic [1:0] k);
    logic [SumW-1:0] s;
    s = SumW'(p) + SumW'(k);
    if (s >= SumW'(Depth)) s = s - SumW'(Depth);
    return PtrW'(s);
  endfunction

  assign n_push      = push_i ? push_data_i.count : 2'd0;
  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  // Take a request only while the worst case of three results still fits.
  assign room_o      = (cnt_q <= CntW'(Depth - MAX_RESULTS));

  assign wr_ptr_d = ptr_add(wr_ptr_q, n_push);
  assign rd_ptr_d = pop ? ptr_add(rd_ptr_q, 2'd1) : rd_ptr_q;
  assign cnt_d    = cnt_q + CntW'(n_push) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (2'(k) < n_push) mem_q[ptr_add(wr_ptr_q, 2'(k))] <= push_data_i.item[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/utf8_to_wide_decoder.sv @@
// Channel  | Direction | Signals                              | Moves
// ---------+-----------+--------------------------------------+-----------------------------
// in       | input     | in_valid_i, in_ready_o, in_data_i    | one UTF-8 byte or end flag
// out      | output    | out_valid_o, out_ready_i, out_data_o | one code unit, last marks end
// cfg      | input     | cfg_we_i, cfg_wdata_i                | unit_mode, written at once
//
// A request is decoded in its accept cycle; its zero to three results enter
// the result queue at that edge, the first shows on out_valid_o in the next
// cycle at the earliest, and the queue drains one result per cycle while
// out_ready_i is high. in_ready_o drops while more than OutDepth - 3 results
// wait, so at the default depth a request leaving two or three results holds
// the input even with out_ready_i high; stalled output holds it until drained.
// Reset clears the open sequence, the queue and the mode (16-bit units).
`default_nettype none

module utf8_to_wide_decoder #(
  parameter int unsigned OutDepth = utfw_pkg::OUT_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  utfw_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output utfw_pkg::out_t out_data_o
);
  import utfw_pkg::*;

  logic accept;
  res_t res;

  // Advance sequence state only on an accepted request.
  assign accept = in_valid_i && in_ready_o;

  // Hold partial sequences, decode completed ones, flag terminators.
  utfw_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .in_data_i  (in_data_i),
    .res_o      (res)
  );

  // Queue the results and drain one per cycle toward the output side while out_ready_i is high.
  utfw_out_queue #(
    .Depth(OutDepth)
  ) u_out_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (accept),
    .push_data_i(res),
    .room_o     (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/utfw_checker.sv @@
`default_nettype none

module utfw_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           cfg_we_i,
  input logic           cfg_wdata_i,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input utfw_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input utfw_pkg::out_t out_data_o
);
  import utfw_pkg::*;

  logic in_acc;
  logic unused_cfg;

  assign in_acc     = in_valid_i && in_ready_o;
  assign unused_cfg = cfg_we_i ^ cfg_wdata_i;

  // A held result stays put until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Backpressure on input only comes from pending results.
  a_ready_needs_backlog: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  // No result appears without an earlier request or backlog.
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(in_acc) && !$past(out_valid_o) |-> !out_valid_o)
    else $error("result without request");

  // An end flag always yields a result on the next cycle.
  a_end_responds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_data_i.end_of_text |=> out_valid_o)
    else $error("end of text produced nothing");

  // The terminator carries a zero unit.
  a_term_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.last |-> out_data_o.code_unit == 32'd0 && !unused_cfg
      || out_valid_o && out_data_o.last && out_data_o.code_unit == 32'd0)
    else $error("terminator with nonzero unit");

endmodule

bind utf8_to_wide_decoder utfw_checker u_utfw_checker (.*);

`default_nettype wire
